>>> sv/nmea_fix_log_filter_top_defines.svh
// Assertion macros shared by the filter RTL.
`ifndef NMEA_FIX_LOG_FILTER_TOP_DEFINES_SVH
`define NMEA_FIX_LOG_FILTER_TOP_DEFINES_SVH

// Same-cycle implication, disabled while reset is low.
`define NFLF_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("nflf: same-cycle check failed");

// Next-cycle implication, disabled while reset is low.
`define NFLF_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("nflf: next-cycle check failed");

`endif

>>> sv/nflf_pkg.sv
`default_nettype none
package nflf_pkg;

    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_NL     = 8'h0A;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_A      = 8'h41;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_G      = 8'h47;
    localparam logic [7:0] CH_P      = 8'h50;
    localparam logic [7:0] CH_N      = 8'h4E;
    localparam logic [7:0] CH_R      = 8'h52;
    localparam logic [7:0] CH_M      = 8'h4D;
    localparam logic [7:0] CH_C      = 8'h43;

    localparam logic [2:0] KIND_OTHER = 3'd0;
    localparam logic [2:0] KIND_GPRMC = 3'd1;
    localparam logic [2:0] KIND_GNRMC = 3'd2;
    localparam logic [2:0] KIND_GPGGA = 3'd3;
    localparam logic [2:0] KIND_GNGGA = 3'd4;

    localparam logic RES_LINE = 1'b0;
    localparam logic RES_WAKE = 1'b1;

    localparam logic CFG_FLUSH_EVERY = 1'b0;
    localparam logic CFG_WAKE_LIMIT  = 1'b1;

    localparam logic [7:0]  SYNC_RESET = 8'd90;
    localparam logic [15:0] WAKE_RESET = 16'd5000;

    localparam int LEN_W   = 10;
    localparam int PAIR_W  = 7;
    localparam int NDIGITS = 6;

    typedef struct packed {
        logic              result_kind;
        logic [2:0]        sentence_kind;
        logic [LEN_W-1:0]  line_length;
        logic              log_line;
        logic              fix_acquired;
        logic              flush_due;
        logic [PAIR_W-1:0] hour;
        logic [PAIR_W-1:0] minute;
        logic [PAIR_W-1:0] second;
        logic [PAIR_W-1:0] day;
        logic [PAIR_W-1:0] month;
        logic [PAIR_W-1:0] year;
    } t_result;

    // Candidate mask (bit k = header k) kept by a byte at header position 1..5.
    function automatic logic [3:0] hdr_match(input logic [2:0] pos, input logic [7:0] b);
        logic [3:0] m;
        m = 4'h0;
        unique case (pos)
            3'd1: m = (b == CH_G) ? 4'hF : 4'h0;
            3'd2: m = {b == CH_N, b == CH_P, b == CH_N, b == CH_P};
            3'd3: m = {b == CH_G, b == CH_G, b == CH_R, b == CH_R};
            3'd4: m = {b == CH_G, b == CH_G, b == CH_M, b == CH_M};
            3'd5: m = {b == CH_A, b == CH_A, b == CH_C, b == CH_C};
            default: m = 4'hF;
        endcase
        return m;
    endfunction

    function automatic logic is_digit(input logic [7:0] b);
        return (b >= CH_ZERO) && (b <= CH_NINE);
    endfunction

    function automatic logic [PAIR_W-1:0] pair_val(input logic ok_hi, input logic [3:0] hi,
                                                  input logic ok_lo, input logic [3:0] lo);
        logic [PAIR_W-1:0] v;
        v = PAIR_W'({hi, 3'b000}) + PAIR_W'({hi, 1'b0}) + PAIR_W'(lo);
        return (ok_hi && ok_lo) ? v : '0;
    endfunction

endpackage
`default_nettype wire

>>> sv/nmea_fix_log_filter_top.sv
// A result reaches the output register in the cycle after its item is accepted.
// Throughput: one item per cycle; the input is taken while the output register is empty
// or being drained in the same cycle.
// Reset (i_rst_n low, synchronous): hunting for '$', standby mode, counters cleared,
// flush interval 90, wake limit 5000, output register empty.
`default_nettype none
`include "nmea_fix_log_filter_top_defines.svh"
module nmea_fix_log_filter_top
    import nflf_pkg::*;
#(
    parameter int MAX_LINE = 512
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_cfg_we,
    input  wire logic                i_cfg_index,
    input  wire logic [15:0]         i_cfg_data,
    input  wire logic                i_in_valid,
    output logic                     o_in_ready,
    input  wire logic                i_action,
    input  wire logic [7:0]          i_rx_byte,
    output logic                     o_out_valid,
    input  wire logic                i_out_ready,
    output logic                     o_result_kind,
    output logic [2:0]               o_sentence_kind,
    output logic [LEN_W-1:0]         o_line_length,
    output logic                     o_log_line,
    output logic                     o_fix_acquired,
    output logic                     o_flush_due,
    output logic [PAIR_W-1:0]        o_hour,
    output logic [PAIR_W-1:0]        o_minute,
    output logic [PAIR_W-1:0]        o_second,
    output logic [PAIR_W-1:0]        o_day,
    output logic [PAIR_W-1:0]        o_month,
    output logic [PAIR_W-1:0]        o_year
);

    localparam int CW = $clog2(MAX_LINE + 1);

    logic [7:0]            r_sync;
    logic [15:0]           r_wake;
    logic                  r_in_line,   n_in_line;
    logic [CW-1:0]         r_byte_cnt,  n_byte_cnt;
    logic [3:0]            r_hdr,       n_hdr;
    logic [3:0]            r_comma,     n_comma;
    logic                  r_closed,    n_closed;
    logic [7:0]            r_status,    n_status;
    logic [7:0]            r_fix,       n_fix;
    logic [NDIGITS-1:0]    r_time_ok,   n_time_ok;
    logic [NDIGITS-1:0][3:0] r_time_val, n_time_val;
    logic [2:0]            r_time_fill, n_time_fill;
    logic                  r_time_on,   n_time_on;
    logic [NDIGITS-1:0]    r_date_ok,   n_date_ok;
    logic [NDIGITS-1:0][3:0] r_date_val, n_date_val;
    logic [2:0]            r_date_fill, n_date_fill;
    logic                  r_date_on,   n_date_on;
    logic                  r_after,     n_after;
    logic                  r_logging,   n_logging;
    logic [7:0]            r_flush_cnt, n_flush_cnt;
    logic [15:0]           r_idle,      n_idle;
    logic                  r_out_valid;
    t_result               r_out,       n_out;
    logic                  n_res;
    logic                  in_acc;

    assign o_in_ready = !r_out_valid || i_out_ready;
    assign in_acc     = i_in_valid && o_in_ready;

    always_comb begin
        logic [CW-1:0] pos;
        logic [7:0]    b;
        logic [8:0]    cnt_inc;
        logic          is_rmc;
        logic          is_gga;
        pos         = '0;
        b           = i_rx_byte;
        cnt_inc     = '0;
        is_rmc      = 1'b0;
        is_gga      = 1'b0;
        n_in_line   = r_in_line;
        n_byte_cnt  = r_byte_cnt;
        n_hdr       = r_hdr;
        n_comma     = r_comma;
        n_closed    = r_closed;
        n_status    = r_status;
        n_fix       = r_fix;
        n_time_ok   = r_time_ok;
        n_time_val  = r_time_val;
        n_time_fill = r_time_fill;
        n_time_on   = r_time_on;
        n_date_ok   = r_date_ok;
        n_date_val  = r_date_val;
        n_date_fill = r_date_fill;
        n_date_on   = r_date_on;
        n_after     = r_after;
        n_logging   = r_logging;
        n_flush_cnt = r_flush_cnt;
        n_idle      = r_idle;
        n_res       = 1'b0;
        n_out       = '0;
        if (in_acc) begin
            if (i_action) begin
                if (r_idle > r_wake) begin
                    n_res             = 1'b1;
                    n_out.result_kind = RES_WAKE;
                    n_idle            = '0;
                end else if (r_idle != '1) begin
                    n_idle = r_idle + 16'd1;
                end
            end else if (b != 8'h00 && (r_in_line || b == CH_DOLLAR)) begin
                if (!r_in_line) begin
                    n_in_line   = 1'b1;
                    n_byte_cnt  = '0;
                    n_hdr       = 4'hF;
                    n_comma     = '0;
                    n_closed    = 1'b0;
                    n_status    = '0;
                    n_fix       = '0;
                    n_time_ok   = '0;
                    n_time_fill = '0;
                    n_time_on   = 1'b0;
                    n_date_ok   = '0;
                    n_date_fill = '0;
                    n_date_on   = 1'b0;
                    n_after     = 1'b0;
                end
                pos        = n_byte_cnt;
                n_byte_cnt = n_byte_cnt + CW'(1);
                if (pos >= CW'(1) && pos <= CW'(5)) begin
                    n_hdr = n_hdr & hdr_match(pos[2:0], b);
                end
                if (n_time_on && n_time_fill < 3'(NDIGITS)) begin
                    n_time_ok[n_time_fill]  = is_digit(b);
                    n_time_val[n_time_fill] = 4'(b - CH_ZERO);
                    n_time_fill             = n_time_fill + 3'd1;
                end
                if (n_date_on && n_date_fill < 3'(NDIGITS)) begin
                    n_date_ok[n_date_fill]  = is_digit(b);
                    n_date_val[n_date_fill] = 4'(b - CH_ZERO);
                    n_date_fill             = n_date_fill + 3'd1;
                end
                if (n_after) begin
                    if (n_comma == 4'd2) begin
                        n_status = b;
                    end else if (n_comma == 4'd6) begin
                        n_fix = b;
                    end
                    n_after = 1'b0;
                end
                if (b <= CH_SPACE) begin
                    n_closed = 1'b1;
                end else if (b == CH_COMMA && !n_closed) begin
                    if (n_comma != 4'hF) begin
                        n_comma = n_comma + 4'd1;
                    end
                    n_after = 1'b1;
                    if (n_comma == 4'd1) begin
                        n_time_on = 1'b1;
                    end
                    if (n_comma == 4'd9) begin
                        n_date_on = 1'b1;
                    end
                end
                if (b == CH_NL) begin
                    if (n_byte_cnt >= CW'(6)) begin
                        priority if (n_hdr[0]) n_out.sentence_kind = KIND_GPRMC;
                        else if (n_hdr[1])     n_out.sentence_kind = KIND_GNRMC;
                        else if (n_hdr[2])     n_out.sentence_kind = KIND_GPGGA;
                        else if (n_hdr[3])     n_out.sentence_kind = KIND_GNGGA;
                        else                   n_out.sentence_kind = KIND_OTHER;
                    end
                    is_rmc = (n_out.sentence_kind == KIND_GPRMC)
                          || (n_out.sentence_kind == KIND_GNRMC);
                    is_gga = (n_out.sentence_kind == KIND_GPGGA)
                          || (n_out.sentence_kind == KIND_GNGGA);
                    if (!r_logging) begin
                        if (is_rmc && n_status == CH_A) begin
                            n_logging          = 1'b1;
                            n_out.fix_acquired = 1'b1;
                        end
                    end else begin
                        n_out.log_line = (is_rmc && n_status == CH_A)
                                      || (is_gga && n_fix != 8'h00 && n_fix != CH_ZERO);
                        cnt_inc = {1'b0, r_flush_cnt} + 9'd1;
                        if (cnt_inc > {1'b0, r_sync}) begin
                            n_out.flush_due = 1'b1;
                            n_flush_cnt     = '0;
                        end else begin
                            n_flush_cnt = cnt_inc[7:0];
                        end
                    end
                    n_out.result_kind = RES_LINE;
                    n_out.line_length = LEN_W'(n_byte_cnt);
                    if (is_rmc) begin
                        n_out.hour   = pair_val(n_time_ok[0], n_time_val[0],
                                                n_time_ok[1], n_time_val[1]);
                        n_out.minute = pair_val(n_time_ok[2], n_time_val[2],
                                                n_time_ok[3], n_time_val[3]);
                        n_out.second = pair_val(n_time_ok[4], n_time_val[4],
                                                n_time_ok[5], n_time_val[5]);
                        n_out.day    = pair_val(n_date_ok[0], n_date_val[0],
                                                n_date_ok[1], n_date_val[1]);
                        n_out.month  = pair_val(n_date_ok[2], n_date_val[2],
                                                n_date_ok[3], n_date_val[3]);
                        n_out.year   = pair_val(n_date_ok[4], n_date_val[4],
                                                n_date_ok[5], n_date_val[5]);
                    end
                    n_idle    = '0;
                    n_in_line = 1'b0;
                    n_res     = 1'b1;
                end else if (n_byte_cnt >= CW'(MAX_LINE)) begin
                    // drop an overrun line
                    n_in_line = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sync      <= SYNC_RESET;
            r_wake      <= WAKE_RESET;
            r_in_line   <= 1'b0;
            r_byte_cnt  <= '0;
            r_hdr       <= '0;
            r_comma     <= '0;
            r_closed    <= 1'b0;
            r_status    <= '0;
            r_fix       <= '0;
            r_time_ok   <= '0;
            r_time_fill <= '0;
            r_time_on   <= 1'b0;
            r_date_ok   <= '0;
            r_date_fill <= '0;
            r_date_on   <= 1'b0;
            r_after     <= 1'b0;
            r_logging   <= 1'b0;
            r_flush_cnt <= '0;
            r_idle      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_FLUSH_EVERY: r_sync <= i_cfg_data[7:0];
                    CFG_WAKE_LIMIT:  r_wake <= i_cfg_data;
                endcase
            end
            r_in_line   <= n_in_line;
            r_byte_cnt  <= n_byte_cnt;
            r_hdr       <= n_hdr;
            r_comma     <= n_comma;
            r_closed    <= n_closed;
            r_status    <= n_status;
            r_fix       <= n_fix;
            r_time_ok   <= n_time_ok;
            r_time_fill <= n_time_fill;
            r_time_on   <= n_time_on;
            r_date_ok   <= n_date_ok;
            r_date_fill <= n_date_fill;
            r_date_on   <= n_date_on;
            r_after     <= n_after;
            r_logging   <= n_logging;
            r_flush_cnt <= n_flush_cnt;
            r_idle      <= n_idle;
            if (n_res) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_time_val <= n_time_val;
        r_date_val <= n_date_val;
        if (n_res) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_result_kind   = r_out.result_kind;
    assign o_sentence_kind = r_out.sentence_kind;
    assign o_line_length   = r_out.line_length;
    assign o_log_line      = r_out.log_line;
    assign o_fix_acquired  = r_out.fix_acquired;
    assign o_flush_due     = r_out.flush_due;
    assign o_hour          = r_out.hour;
    assign o_minute        = r_out.minute;
    assign o_second        = r_out.second;
    assign o_day           = r_out.day;
    assign o_month         = r_out.month;
    assign o_year          = r_out.year;

    `NFLF_ASSERT_IMP(a_no_accept_when_blocked, i_clk, i_rst_n,
        r_out_valid && !i_out_ready, !o_in_ready)
    `NFLF_ASSERT_IMP(a_wake_fields_clear, i_clk, i_rst_n,
        r_out_valid && r_out.result_kind == RES_WAKE,
        r_out.sentence_kind == KIND_OTHER && r_out.line_length == '0
            && !r_out.log_line && !r_out.flush_due)
    `NFLF_ASSERT_IMP(a_flush_only_logging, i_clk, i_rst_n,
        r_out_valid && r_out.flush_due, r_logging && !r_out.fix_acquired)
    `NFLF_ASSERT_IMP(a_line_within_limit, i_clk, i_rst_n,
        r_in_line, r_byte_cnt < CW'(MAX_LINE))
    `NFLF_ASSERT_NXT(a_acquire_sets_logging, i_clk, i_rst_n,
        n_res && n_out.fix_acquired, r_logging)

endmodule
`default_nettype wire
